>>> rtl/core/lbts_pkg.sv
// lbts_pkg: shared widths, codes, queue word type and helper for the texel shader
// no dependencies; imported by every module of the block
`default_nettype none

package lbts_pkg;

  // stream and field widths
  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int CH         = 3;
  localparam int IN_DATA_W  = 5 * WORD_W;

  // light arithmetic
  localparam int EDGE_W     = 27;
  localparam int ROW_W      = 21;
  localparam int LIGHT_W    = 20;
  localparam int ROW_SHIFT  = 6;
  localparam int LIGHT_POS  = 16;
  localparam int FRAC_SHIFT = 18;
  localparam int PROD_W     = BYTE_W + LIGHT_W;
  localparam int SAT_W      = PROD_W - FRAC_SHIFT;
  localparam logic [BYTE_W-1:0] SAT_MAX = 8'd255;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam int MIP_W      = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIP_LEVEL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLORED_MODE = 1'b1;

  // item kinds
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TEXEL = 1'b1;

  // defaults for top-level parameters
  localparam int BLOCK_SIDE_LOG2_DEF = 4;
  localparam int QUEUE_DEPTH_DEF     = 4;

  typedef logic [CH-1:0][LIGHT_W-1:0] light_vec_t;

  // one texel word in flight between front and back
  typedef struct packed {
    logic [WORD_W-1:0] texel;
    light_vec_t        light;
    logic              row_end;
    logic              block_end;
  } lbts_entry_t;

  // 3 * (a - b) << 16 as a signed edge value
  function automatic logic signed [EDGE_W-1:0] tri_shift(input logic [BYTE_W-1:0] a,
                                                         input logic [BYTE_W-1:0] b);
    logic signed [EDGE_W-LIGHT_POS-1:0] d;
    logic signed [EDGE_W-LIGHT_POS-1:0] t;
    d = $signed({3'b000, a}) - $signed({3'b000, b});
    t = d + (d <<< 1);
    return $signed({t, {LIGHT_POS{1'b0}}});
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lbts_front.sv
// lbts_front: accepts stream words, keeps edge and row light state, queues lit-ready texels
// depends on lbts_pkg
`default_nettype none

module lbts_front #(
  parameter int BLOCK_SIDE_LOG2 = lbts_pkg::BLOCK_SIDE_LOG2_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lbts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [lbts_pkg::WORD_W-1:0]     corner_top_left,
  input  logic [lbts_pkg::WORD_W-1:0]     corner_top_right,
  input  logic [lbts_pkg::WORD_W-1:0]     corner_bottom_left,
  input  logic [lbts_pkg::WORD_W-1:0]     corner_bottom_right,
  input  logic [lbts_pkg::WORD_W-1:0]     texel_color,
  output logic                            push,
  output lbts_pkg::lbts_entry_t           push_data,
  input  logic                            q_full
);
  import lbts_pkg::*;

  localparam int SIDE_W = $clog2(BLOCK_SIDE_LOG2 + 1);
  localparam int SHW    = $clog2(BLOCK_SIDE_LOG2 + ROW_SHIFT + 1);
  localparam logic [BLOCK_SIDE_LOG2-1:0] ONES = '1;

  // control state
  logic [MIP_W-1:0]           mip_level;
  logic                       colored_mode;
  logic                       active;
  logic [SIDE_W-1:0]          side_log2;
  logic                       block_colored;
  logic [BLOCK_SIDE_LOG2-1:0] column_count;
  logic [BLOCK_SIDE_LOG2-1:0] row_count;

  // per-component light state; right edge kept as a difference to the left edge
  logic signed [EDGE_W-1:0] edge_left      [CH];
  logic signed [EDGE_W-1:0] edge_left_step [CH];
  logic signed [EDGE_W-1:0] edge_diff      [CH];
  logic signed [EDGE_W-1:0] edge_diff_step [CH];
  logic signed [ROW_W-1:0]  row_light      [CH];
  logic signed [ROW_W-1:0]  row_step       [CH];

  // load-time values
  logic [SIDE_W-1:0]        side_calc;
  logic [SHW-1:0]           shift_load;
  logic signed [EDGE_W-1:0] el_load  [CH];
  logic signed [EDGE_W-1:0] els_load [CH];
  logic signed [EDGE_W-1:0] ers_load [CH];
  logic signed [EDGE_W-1:0] ed_load  [CH];
  logic signed [EDGE_W-1:0] rs_wide_load [CH];

  // texel-time values
  logic [SHW-1:0]           shift_row;
  logic signed [EDGE_W-1:0] el_next   [CH];
  logic signed [EDGE_W-1:0] ed_next   [CH];
  logic signed [EDGE_W-1:0] rs_wide_next [CH];
  logic signed [ROW_W-1:0]  rl_src    [CH];

  logic [BLOCK_SIDE_LOG2-1:0] side_mask;
  logic                       last_col;
  logic                       last_row;
  logic                       accept;
  logic                       load;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign load     = accept && (in_cmd == CMD_LOAD);
  assign push     = accept && (in_cmd == CMD_TEXEL) && active;

  assign side_mask = ~(ONES << side_log2);
  assign last_col  = column_count >= side_mask;
  assign last_row  = row_count >= side_mask;

  always_comb begin
    if (BLOCK_SIDE_LOG2 > int'(mip_level)) begin
      side_calc = SIDE_W'(BLOCK_SIDE_LOG2 - int'(mip_level));
    end else begin
      side_calc = '0;
    end
    shift_load = SHW'(side_calc) + SHW'(ROW_SHIFT);
    shift_row  = SHW'(side_log2) + SHW'(ROW_SHIFT);
    for (int k = 0; k < CH; k++) begin
      el_load[k]  = tri_shift(corner_top_left[BYTE_W*k +: BYTE_W], '0);
      els_load[k] = tri_shift(corner_bottom_left[BYTE_W*k +: BYTE_W],
                              corner_top_left[BYTE_W*k +: BYTE_W]) >>> side_calc;
      ers_load[k] = tri_shift(corner_bottom_right[BYTE_W*k +: BYTE_W],
                              corner_top_right[BYTE_W*k +: BYTE_W]) >>> side_calc;
      ed_load[k]  = tri_shift(corner_top_right[BYTE_W*k +: BYTE_W],
                              corner_top_left[BYTE_W*k +: BYTE_W]);
      rs_wide_load[k] = ed_load[k] >>> shift_load;

      el_next[k]      = edge_left[k] + edge_left_step[k];
      ed_next[k]      = edge_diff[k] + edge_diff_step[k];
      rs_wide_next[k] = ed_next[k] >>> shift_row;

      // grayscale takes component 0 everywhere; a negative light counts as dark
      rl_src[k] = block_colored ? row_light[k] : row_light[0];
      push_data.light[k] = rl_src[k][ROW_W-1] ? '0 : rl_src[k][LIGHT_W-1:0];
    end
    push_data.texel     = texel_color;
    push_data.row_end   = last_col;
    push_data.block_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mip_level     <= '0;
      colored_mode  <= 1'b1;
      active        <= 1'b0;
      side_log2     <= '0;
      block_colored <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIP_LEVEL:    mip_level    <= cfg_data[MIP_W-1:0];
          CFG_COLORED_MODE: colored_mode <= cfg_data[0];
          default:          ;
        endcase
      end
      if (load) begin
        side_log2     <= side_calc;
        block_colored <= colored_mode;
        active        <= 1'b1;
        column_count  <= '0;
        row_count     <= '0;
      end else if (push) begin
        if (last_col) begin
          column_count <= '0;
          if (last_row) begin
            row_count <= '0;
            active    <= 1'b0;
          end else begin
            row_count <= row_count + 1'b1;
          end
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CH; k++) begin
      if (load) begin
        edge_left[k]      <= el_load[k];
        edge_left_step[k] <= els_load[k];
        edge_diff[k]      <= ed_load[k];
        edge_diff_step[k] <= ers_load[k] - els_load[k];
        row_light[k]      <= el_load[k][ROW_SHIFT +: ROW_W];
        row_step[k]       <= rs_wide_load[k][ROW_W-1:0];
      end else if (push) begin
        if (last_col) begin
          edge_left[k] <= el_next[k];
          edge_diff[k] <= ed_next[k];
        end
        if (last_col && !last_row) begin
          row_light[k] <= el_next[k][ROW_SHIFT +: ROW_W];
          row_step[k]  <= rs_wide_next[k][ROW_W-1:0];
        end else begin
          row_light[k] <= row_light[k] + row_step[k];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lbts_queue.sv
// lbts_queue: short register queue of texel words between front and back
// depends on lbts_pkg
`default_nettype none

module lbts_queue #(
  parameter int DEPTH = lbts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lbts_pkg::lbts_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output lbts_pkg::lbts_entry_t pop_data,
  output logic                  not_empty
);
  import lbts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lbts_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lbts_back.sv
// lbts_back: multiplies colour bytes by light, saturates, holds the output register
// depends on lbts_pkg
`default_nettype none

module lbts_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  lbts_pkg::lbts_entry_t       q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lbts_pkg::WORD_W-1:0] lit_color,
  output logic                        row_end,
  output logic                        block_end
);
  import lbts_pkg::*;

  logic [PROD_W-1:0] prod [CH];
  logic [SAT_W-1:0]  scaled [CH];
  logic [WORD_W-1:0] lit_next;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    lit_next = '0;
    for (int k = 0; k < CH; k++) begin
      prod[k]   = PROD_W'(q_data.texel[BYTE_W*k +: BYTE_W]) * PROD_W'(q_data.light[k]);
      scaled[k] = prod[k][PROD_W-1:FRAC_SHIFT];
      lit_next[BYTE_W*k +: BYTE_W] = (|scaled[k][SAT_W-1:BYTE_W]) ? SAT_MAX
                                                                  : scaled[k][BYTE_W-1:0];
    end
    lit_next[WORD_W-1 -: BYTE_W] = q_data.texel[WORD_W-1 -: BYTE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lit_color <= lit_next;
      row_end   <= q_data.row_end;
      block_end <= q_data.block_end;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lightmap_block_texel_shader.sv
// lightmap_block_texel_shader: top level, bilinear lightmap modulation of one texel block
// depends on lbts_pkg, lbts_front, lbts_queue, lbts_back
//
//  channel  | dir | handshake              | word contents (lowest bit first)
//  ---------+-----+------------------------+------------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: corner tl, tr, bl, br, texel (32b each)
//           |     |                        | tuser: cmd (0 load corners, 1 texel)
//  m_axis   | out | m_axis_tvalid/tready   | tdata: lit_color; tuser: row_end; tlast: block_end
//  cfg      | in  | cfg_we                 | cfg_index 0 mip_level, 1 colored_mode; cfg_data
//
//  one word per cycle sustained while the queue is not full; a texel's light is picked up as
//  it is taken, then the texel is written into the queue and, once popped, multiplied into
//  the output register; s_axis_tready drops only when the front-to-back queue is full
//  a stalled output holds its register while the queue keeps absorbing texels
//  reset clears control state only; no clearing pass, block is ready after reset
`default_nettype none

module lightmap_block_texel_shader #(
  parameter int BLOCK_SIDE_LOG2 = lbts_pkg::BLOCK_SIDE_LOG2_DEF,
  parameter int QUEUE_DEPTH     = lbts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [lbts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbts_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lbts_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // corner_top_left, corner_top_right,
                                                          // corner_bottom_left,
                                                          // corner_bottom_right, texel_color
  input  logic                             s_axis_tuser,  // cmd
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lbts_pkg::WORD_W-1:0]      m_axis_tdata,  // lit_color
  output logic                             m_axis_tuser,  // row_end
  output logic                             m_axis_tlast   // block_end
);
  import lbts_pkg::*;

  // queue handshake between the two halves
  lbts_entry_t push_data;
  lbts_entry_t pop_data;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_not_empty;

  // front: latches config at each load, steps row lights per texel and edge lights per row
  lbts_front #(
    .BLOCK_SIDE_LOG2(BLOCK_SIDE_LOG2)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (s_axis_tvalid),
    .in_ready           (s_axis_tready),
    .in_cmd             (s_axis_tuser),
    .corner_top_left    (s_axis_tdata[0*WORD_W +: WORD_W]),
    .corner_top_right   (s_axis_tdata[1*WORD_W +: WORD_W]),
    .corner_bottom_left (s_axis_tdata[2*WORD_W +: WORD_W]),
    .corner_bottom_right(s_axis_tdata[3*WORD_W +: WORD_W]),
    .texel_color        (s_axis_tdata[4*WORD_W +: WORD_W]),
    .push               (push),
    .push_data          (push_data),
    .q_full             (q_full)
  );

  // short queue so that an output stall does not stop the front at once
  lbts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .pop_data (pop_data),
    .not_empty(q_not_empty)
  );

  // back: three byte-by-light multiplies, saturate, output register
  lbts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_pop    (pop),
    .q_data   (pop_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .lit_color(m_axis_tdata),
    .row_end  (m_axis_tuser),
    .block_end(m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> sim/lightmap_block_texel_shader_test.sv
// lightmap_block_texel_shader_test: self-checking bench for the lightmap texel shader
// depends on lbts_pkg and lightmap_block_texel_shader; a built-in shading predictor
// supplies the expected lit words
module lightmap_block_texel_shader_test;
  import lbts_pkg::*;

  localparam int SIDE_LOG2   = BLOCK_SIDE_LOG2_DEF;
  localparam int SETTLE      = 8;        // a load gives no word, so let it clear the front
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MAX   = 10;

  typedef logic signed [EDGE_W-1:0] edge_light_t;
  typedef logic signed [ROW_W-1:0]  row_light_t;

  // one lit word as it should leave the block
  typedef struct packed {
    logic [WORD_W-1:0] color;
    logic              row_end;
    logic              block_end;
  } lit_word_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_MIP_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // corner tl, tr, bl, br, texel colour
  logic                  s_axis_tuser  = CMD_LOAD;  // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [WORD_W-1:0]     m_axis_tdata;  // lit colour
  logic                  m_axis_tuser;  // row end
  logic                  m_axis_tlast;  // block end

  lightmap_block_texel_shader #(.BLOCK_SIDE_LOG2(SIDE_LOG2)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shading predictor: register copies, latched block settings and light state
  // ---------------------------------------------------------------------------
  logic [MIP_W-1:0] mip_reg;
  logic             colored_reg;
  edge_light_t      left_light [CH];
  edge_light_t      right_light[CH];
  edge_light_t      left_step  [CH];
  edge_light_t      right_step [CH];
  row_light_t       span_light [CH];
  row_light_t       span_step  [CH];
  int unsigned      col_pos, row_pos, blk_log2;
  bit               blk_live, blk_colored;
  lit_word_t        pending_lit[$];

  // run bookkeeping
  int send_idle_pct = 18;
  int recv_idle_pct = 47;
  int words_taken   = 0;
  int lit_seen      = 0;
  int reg_writes    = 0;
  int fault_count   = 0;
  int cycle_count   = 0;

  function automatic void clear_shading();
    mip_reg     = '0;
    colored_reg = 1'b1;
    for (int k = 0; k < CH; k++) begin
      left_light[k]  = '0;
      right_light[k] = '0;
      left_step[k]   = '0;
      right_step[k]  = '0;
      span_light[k]  = '0;
      span_step[k]   = '0;
    end
    col_pos     = 0;
    row_pos     = 0;
    blk_live    = 1'b0;
    blk_log2    = 0;
    blk_colored = 1'b0;
  endfunction

  // row start light from the left edge, per-texel step from the edge spread
  function automatic void start_row();
    for (int k = 0; k < CH; k++) begin
      span_light[k] = row_light_t'(longint'(left_light[k]) >>> ROW_SHIFT);
      span_step[k]  = row_light_t'((longint'(right_light[k]) - longint'(left_light[k]))
                                   >>> (blk_log2 + ROW_SHIFT));
    end
  endfunction

  function automatic void load_corners(input logic [IN_DATA_W-1:0] d);
    longint tl, tr, bl, br;
    int     s;
    s           = SIDE_LOG2 - int'(mip_reg);
    blk_log2    = (s < 0) ? 0 : s;  // never below a single texel
    blk_colored = colored_reg;
    for (int k = 0; k < CH; k++) begin
      tl = longint'(d[0*WORD_W + BYTE_W*k +: BYTE_W]);
      tr = longint'(d[1*WORD_W + BYTE_W*k +: BYTE_W]);
      bl = longint'(d[2*WORD_W + BYTE_W*k +: BYTE_W]);
      br = longint'(d[3*WORD_W + BYTE_W*k +: BYTE_W]);
      left_light[k]  = edge_light_t'(3 * (tl << LIGHT_POS));
      right_light[k] = edge_light_t'(3 * (tr << LIGHT_POS));
      left_step[k]   = edge_light_t'((3 * (bl << LIGHT_POS) - 3 * (tl << LIGHT_POS)) >>> blk_log2);
      right_step[k]  = edge_light_t'((3 * (br << LIGHT_POS) - 3 * (tr << LIGHT_POS)) >>> blk_log2);
    end
    col_pos  = 0;
    row_pos  = 0;
    blk_live = 1'b1;
    start_row();
  endfunction

  // returns 0 when the texel is dropped for want of an open block
  function automatic bit light_texel(input logic [WORD_W-1:0] texel);
    lit_word_t   w;
    longint      lgt, c;
    int unsigned mask;
    bit          last_col, last_row;
    if (!blk_live) return 1'b0;
    w.color = {texel[WORD_W-1 -: BYTE_W], {(CH*BYTE_W){1'b0}}};  // alpha untouched
    for (int k = 0; k < CH; k++) begin
      lgt = blk_colored ? longint'(span_light[k]) : longint'(span_light[0]);
      if (lgt < 0) lgt = 0;
      c = (longint'(texel[BYTE_W*k +: BYTE_W]) * lgt) >>> FRAC_SHIFT;
      if (c > longint'(SAT_MAX)) c = longint'(SAT_MAX);
      w.color[BYTE_W*k +: BYTE_W] = c[BYTE_W-1:0];
    end
    for (int k = 0; k < CH; k++) span_light[k] = span_light[k] + span_step[k];
    mask        = (1 << blk_log2) - 1;
    last_col    = col_pos >= mask;
    last_row    = row_pos >= mask;
    w.row_end   = last_col;
    w.block_end = last_col && last_row;
    pending_lit.push_back(w);
    if (last_col) begin
      col_pos = 0;
      for (int k = 0; k < CH; k++) begin
        left_light[k]  = left_light[k] + left_step[k];
        right_light[k] = right_light[k] + right_step[k];
      end
      if (last_row) begin
        row_pos  = 0;
        blk_live = 1'b0;
      end else begin
        row_pos++;
        start_row();
      end
    end else begin
      col_pos++;
    end
    return 1'b1;
  endfunction

  function automatic bit shade_word(input logic cmd, input logic [IN_DATA_W-1:0] d);
    if (cmd == CMD_LOAD) begin
      load_corners(d);
      return 1'b1;
    end
    return light_texel(d[4*WORD_W +: WORD_W]);
  endfunction

  // ---------------------------------------------------------------------------
  // driving side; every task starts and ends on a rising edge
  // ---------------------------------------------------------------------------

  // tready is sampled at the falling edge, where nothing moves, and the word is
  // taken at the rising edge that follows
  task automatic send_word(input logic cmd, input logic [IN_DATA_W-1:0] d);
    int gap;
    bit taken;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= cmd;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end
    if (shade_word(cmd, d)) words_taken++;
  endtask

  // unused texel field of a load still carries random bits
  task automatic send_load(input logic [WORD_W-1:0] tl, tr, bl, br);
    send_word(CMD_LOAD, {WORD_W'($urandom()), br, bl, tr, tl});
  endtask

  task automatic send_texel(input logic [WORD_W-1:0] texel);
    send_word(CMD_TEXEL, {texel, WORD_W'($urandom()), WORD_W'($urandom()),
                          WORD_W'($urandom()), WORD_W'($urandom())});
  endtask

  // mostly random, with all-zero and all-one words mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return WORD_W'($urandom());
  endfunction

  // stop sending and wait for every lit word, then let a trailing load settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_lit.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // both registers, back to back; upper data bit of the mode write is don't-care
  task automatic set_shading(input logic [MIP_W-1:0] mip, input logic colored);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIP_LEVEL;
    cfg_data  <= CFG_DATA_W'(mip);
    @(posedge clk);
    mip_reg = mip;
    cfg_index <= CFG_COLORED_MODE;
    cfg_data  <= {1'($urandom_range(1)), colored};
    @(posedge clk);
    colored_reg = colored;
    cfg_we <= 1'b0;
    reg_writes += 2;
  endtask

  // receiver stalls at the rate the current phase asks
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // ---------------------------------------------------------------------------
  // checking side
  // ---------------------------------------------------------------------------
  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= SHOWN_MAX) $display("mismatch: %s", what);
  endtask

  always @(negedge clk) begin
    lit_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      lit_seen++;
      if (pending_lit.size() == 0) begin
        note_fault($sformatf("unexpected word %08h row_end %0b block_end %0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = pending_lit.pop_front();
        if (m_axis_tdata !== want.color || m_axis_tuser !== want.row_end ||
            m_axis_tlast !== want.block_end)
          note_fault($sformatf("word %0d expected %08h/%0b/%0b got %08h/%0b/%0b",
                               lit_seen, want.color, want.row_end, want.block_end,
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a texel with no open block must vanish
  task automatic test_texel_without_block();
    send_texel('1);
    drain_results();
  endtask

  // two-texel side, full corners: colour bytes above 85 clip at 255
  task automatic test_saturation_extremes();
    set_shading(2'd3, 1'b1);
    send_load('1, '1, '1, '1);
    send_texel('1);
    send_texel('0);
    send_texel(32'h80FF01FE);
    send_texel(32'h7F00FF80);
    send_texel(32'h5A5A5A5A);  // block already closed, dropped
    drain_results();
  endtask

  // opposing edge slopes, then a second load cuts the block short
  task automatic test_load_restart();
    send_load('0, '1, '1, '0);
    send_texel(32'hFF808080);
    send_texel(32'h00FFFFFF);
    send_load(32'h12FF8001, 32'h00000000, 32'hFFFFFFFF, 32'h0040C0FF);
    send_texel(32'h11223344);
    send_texel(32'hFFFFFFFF);
    drain_results();
  endtask

  // new settings mid-block only bite at the next load
  task automatic test_register_latch();
    set_shading(2'd0, 1'b0);
    send_texel(32'hA5C3E1F0);
    send_texel(32'h0F1E2D3C);
    send_load(32'h00FF40C0, 32'hFF0080FF, 32'h8020FF00, 32'h00000080);
    send_texel(32'hFFFFFFFF);
    send_texel(32'h80808080);
    send_texel(32'h01020304);
    drain_results();
  endtask

  // mostly complete blocks with random content; some noise texels, some short
  // blocks that the next load restarts, some strays after the block end
  task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                     input int quota);
    int               start, blocks, side, n;
    int unsigned      r;
    logic [MIP_W-1:0] mip;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    start         = words_taken;
    while (words_taken - start < quota) begin
      r   = $urandom_range(99);
      mip = (r < 10) ? 2'd0 : (r < 30) ? 2'd1 : (r < 60) ? 2'd2 : 2'd3;
      drain_results();
      set_shading(mip, 1'($urandom_range(1)));
      blocks = (mip == 0) ? 1 : 3;  // full-size blocks kept rare
      repeat (blocks) begin
        if ($urandom_range(99) < 6) send_texel(pick_word());
        send_load(pick_word(), pick_word(), pick_word(), pick_word());
        side = 1 << blk_log2;
        n    = side * side;
        if ($urandom_range(99) < 8) n = $urandom_range(n - 1, 1);
        repeat (n) send_texel(pick_word());
        if ($urandom_range(99) < 8) send_texel(pick_word());
      end
    end
  endtask

  initial begin
    clear_shading();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_texel_without_block();
    test_saturation_extremes();
    test_load_restart();
    test_register_latch();
    test_random_traffic(18, 47, 450);
    test_random_traffic(47, 18, 450);
    test_random_traffic(0, 0, 450);

    drain_results();
    if (pending_lit.size() != 0) note_fault("lit words still outstanding at the end");

    $display("%0d words taken (loads and lit texels), %0d lit words compared, %0d register writes",
             words_taken, lit_seen, reg_writes);
    $display("idle and stall mixes: sender-heavy, receiver-heavy, none; %0d faults",
             fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
